// ----- rtl/emo_pkg.sv -----
//------------------------------------------------------------------------------
// emo_pkg
// shared types and constants of the enveloped multiwave oscillator
//------------------------------------------------------------------------------
package emo_pkg;

    localparam int SineTableBits = 10;

    localparam logic [31:0] LfsrMask = 32'hD000_0001;
    localparam logic [31:0] BaseIncReset = 32'd13421773;
    localparam logic [15:0] AmpReset = 16'd32768;
    localparam logic [31:0] SeedReset = 32'd100;

    localparam logic [16:0] PolyA = 17'd102944;
    localparam logic [16:0] PolyB = 17'd42048;
    localparam logic [16:0] PolyC = 17'd4640;
    localparam logic [11:0] WalkScale = 12'd3277;

    localparam logic [2:0] WaveSine = 3'd0;
    localparam logic [2:0] WaveSquare = 3'd1;
    localparam logic [2:0] WaveTriangle = 3'd2;
    localparam logic [2:0] WaveSaw = 3'd3;
    localparam logic [2:0] WaveWhite = 3'd4;
    localparam logic [2:0] WavePink = 3'd5;
    localparam logic [2:0] WaveBrown = 3'd6;

    localparam logic [1:0] RegWaveform = 2'd0;
    localparam logic [1:0] RegBaseInc = 2'd1;
    localparam logic [1:0] RegAmplitude = 2'd2;
    localparam logic [1:0] RegSeed = 2'd3;

    typedef struct packed {
        logic [2:0] waveform;
        logic [31:0] base_increment;
        logic [15:0] amplitude;
    } cfg_t;

    function automatic logic [31:0] lfsr_next(input logic [31:0] r);
        lfsr_next = r[0] ? ((r >> 1) ^ LfsrMask) : (r >> 1);
    endfunction

endpackage

// ----- rtl/emo_cfg.sv -----
//------------------------------------------------------------------------------
// emo_cfg
// apb register file of the oscillator
//------------------------------------------------------------------------------
module emo_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output emo_pkg::cfg_t       cfg,
    output logic                seed_wr,
    output logic [31:0]         seed_val
);
    import emo_pkg::*;

    logic [2:0]  waveform_reg;
    logic [31:0] base_inc_reg;
    logic [15:0] amplitude_reg;
    logic [31:0] seed_reg;
    logic        wr;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WaveSine;
            base_inc_reg <= BaseIncReset;
            amplitude_reg <= AmpReset;
            seed_reg <= SeedReset;
        end
        else if (wr)
        begin
            case (idx)
                RegWaveform: waveform_reg <= pwdata[2:0];
                RegBaseInc: base_inc_reg <= pwdata;
                RegAmplitude: amplitude_reg <= pwdata[15:0];
                RegSeed: seed_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            RegWaveform: prdata = {29'd0, waveform_reg};
            RegBaseInc: prdata = base_inc_reg;
            RegAmplitude: prdata = {16'd0, amplitude_reg};
            RegSeed: prdata = seed_reg;
            default: prdata = 32'd0;
        endcase
    end

    assign cfg.waveform = waveform_reg;
    assign cfg.base_increment = base_inc_reg;
    assign cfg.amplitude = amplitude_reg;
    assign seed_wr = wr && (idx == RegSeed);
    assign seed_val = pwdata;
endmodule

// ----- rtl/enveloped_multiwave_oscillator_unit.sv -----
//------------------------------------------------------------------------------
// enveloped_multiwave_oscillator_unit
// phase accumulator oscillator with envelopes and fm
//------------------------------------------------------------------------------
// One word in gives one sample out. A single shared 33x33 multiplier is stepped
// by a small sequencer through the gain, waveform (four sine polynomial
// products for sine and selector seven, or the brownian walk scale), output
// scale and the two phase increment products. The input stalls while a word is
// in work, so a new word is taken only once the last is through. A finished
// sample waits in an output register, so the next word can start while it is
// held; the sequencer waits in its last step only while the earlier sample has
// still not been taken.
//------------------------------------------------------------------------------
module enveloped_multiwave_oscillator_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        amp_env,
    input  logic [15:0]        freq_env,
    input  logic signed [15:0] fm_amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample_out
);
    import emo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAIN = 4'd1;
    localparam logic [3:0] S_Z2   = 4'd2;
    localparam logic [3:0] S_T1   = 4'd3;
    localparam logic [3:0] S_T2   = 4'd4;
    localparam logic [3:0] S_T3   = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_WAVE = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_INC  = 4'd9;
    localparam logic [3:0] S_DLT  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    cfg_t        cfg;
    logic        seed_wr;
    logic [31:0] seed_val;

    emo_cfg u_cfg
    (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cfg(cfg), .seed_wr(seed_wr), .seed_val(seed_val)
    );

    logic [3:0]         state_reg, state_next;
    logic [31:0]        phase_reg;
    logic [31:0]        noise_reg;
    logic signed [15:0] brown_reg;
    logic [15:0]        amp_env_reg, freq_env_reg;
    logic signed [15:0] fm_reg;
    logic [15:0]        gain_reg;
    logic signed [16:0] wave_reg;
    logic [16:0]        z_reg, z2_reg;
    logic [32:0]        t_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [15:0] res_reg;
    logic signed [15:0] sample_reg;
    logic               done_go;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic [31:0] phase_keep;
    logic [15:0] frac;
    logic [16:0] z_new;
    logic [31:0] l1, l2;
    logic signed [17:0] bnext;
    logic signed [15:0] walk_s;
    logic signed [17:0] tri_v;
    logic signed [17:0] saw_v;
    logic signed [49:0] outv;

    assign mul_p = mul_a * mul_b;

    assign phase_keep = phase_reg & ~((32'd1 << (32 - SineTableBits)) - 32'd1);
    assign frac = phase_keep[29:14];
    assign z_new = phase_keep[30] ? (17'd65536 - {1'b0, frac}) : {1'b0, frac};
    assign l1 = lfsr_next(noise_reg);
    assign l2 = lfsr_next(l1);
    assign walk_s = neg_reg ? -$signed(mul_p[31:16]) : $signed(mul_p[31:16]);
    assign bnext = 18'(brown_reg) + 18'(walk_s);
    assign tri_v = phase_reg[31] ? (18'sd98304 - $signed({1'b0, phase_reg[31:15]}))
                                 : ($signed({1'b0, phase_reg[31:15]}) - 18'sd32768);
    assign saw_v = 18'sd32768 - $signed({2'b0, phase_reg[31:16]});
    assign outv = mul_p[49:0] + 50'sd16384;

    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign sample_out = sample_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GAIN: begin mul_a = {17'd0, cfg.amplitude}; mul_b = {17'd0, amp_env_reg}; end
            S_Z2:   begin mul_a = {16'd0, z_reg}; mul_b = {16'd0, z_reg}; end
            S_T1:   begin mul_a = {16'd0, PolyC}; mul_b = {16'd0, z2_reg}; end
            S_T2:   begin mul_a = t_reg; mul_b = {16'd0, z2_reg}; end
            S_T3:   begin mul_a = t_reg; mul_b = {16'd0, z_reg}; end
            S_WALK: begin mul_a = {17'd0, noise_reg[31:16]}; mul_b = {21'd0, WalkScale}; end
            S_OUT:  begin mul_a = {17'd0, gain_reg}; mul_b = 33'(wave_reg); end
            S_INC:  begin mul_a = {1'b0, cfg.base_increment}; mul_b = {17'd0, freq_env_reg}; end
            S_DLT:  begin mul_a = t_reg; mul_b = 33'sd32768 + 33'(fm_reg); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid && !in_stall) state_next = S_GAIN;
            S_GAIN:
            begin
                case (cfg.waveform)
                    WaveSquare, WaveTriangle, WaveSaw, WaveWhite, WavePink:
                        state_next = S_WAVE;
                    WaveBrown: state_next = S_WALK;
                    default: state_next = S_Z2;
                endcase
            end
            S_Z2: state_next = S_T1;
            S_T1: state_next = S_T2;
            S_T2: state_next = S_T3;
            S_T3: state_next = S_OUT;
            S_WALK: state_next = S_OUT;
            S_WAVE: state_next = S_OUT;
            S_OUT: state_next = S_INC;
            S_INC: state_next = S_DLT;
            S_DLT: state_next = S_DONE;
            S_DONE: if (done_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            noise_reg <= SeedReset;
            brown_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_go)
            begin
                phase_reg <= phase_reg + t_reg[31:0];
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (seed_wr)
                noise_reg <= seed_val;
            else if (state_reg == S_GAIN && cfg.waveform == WaveWhite)
                noise_reg <= l1;
            else if (state_reg == S_GAIN && cfg.waveform == WaveBrown)
                noise_reg <= l2;
            if (state_reg == S_WALK)
            begin
                if (bnext > 18'sd32767 || bnext < -18'sd32768)
                    brown_reg <= brown_reg - walk_s;
                else
                    brown_reg <= bnext[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                amp_env_reg <= amp_env;
                freq_env_reg <= freq_env;
                fm_reg <= fm_amount;
            end
            S_GAIN:
            begin
                gain_reg <= (mul_p[32:31] != 2'd0) ? 16'hFFFF : mul_p[30:15];
                z_reg <= z_new;
                if (cfg.waveform == WaveBrown)
                    neg_reg <= l1[0];
                case (cfg.waveform)
                    WaveSquare: wave_reg <= phase_reg[31] ? 17'sd32767 : -17'sd32768;
                    WaveTriangle: wave_reg <= (tri_v > 18'sd32767) ? 17'sd32767 : tri_v[16:0];
                    WaveSaw: wave_reg <= (saw_v > 18'sd32767) ? 17'sd32767 : saw_v[16:0];
                    WaveWhite: wave_reg <= $signed({1'b0, l1[31:16]}) - 17'sd32768;
                    default: wave_reg <= '0;
                endcase
            end
            S_WALK:
            begin
                if (bnext > 18'sd32767 || bnext < -18'sd32768)
                    wave_reg <= 17'(brown_reg - walk_s);
                else
                    wave_reg <= 17'($signed(bnext[15:0]));
            end
            S_Z2: z2_reg <= mul_p[32:16];
            S_T1: t_reg <= {16'd0, PolyB - mul_p[32:16]};
            S_T2: t_reg <= {16'd0, PolyA - mul_p[32:16]};
            S_T3:
            begin
                if (mul_p[33:17] + 17'd1 > 17'd65535 || mul_p[33:16] + 18'd1 > 18'd65535)
                    wave_reg <= phase_keep[31] ? -17'sd32767 : 17'sd32767;
                else
                    wave_reg <= phase_keep[31] ? -$signed({1'b0, 16'((mul_p[33:16] + 18'd1) >> 1)})
                                               : $signed({1'b0, 16'((mul_p[33:16] + 18'd1) >> 1)});
            end
            S_OUT:
            begin
                if ((outv >>> 15) > 50'sd32767)
                    res_reg <= 16'sd32767;
                else if ((outv >>> 15) < -50'sd32768)
                    res_reg <= -16'sd32768;
                else
                    res_reg <= outv[30:15];
            end
            S_INC: t_reg <= (mul_p[48:47] != 2'd0) ? {1'b0, 32'hFFFF_FFFF} : {1'b0, mul_p[46:15]};
            S_DLT: t_reg <= (mul_p[49:47] != 3'd0) ? {1'b0, 32'hFFFF_FFFF} : {1'b0, mul_p[46:15]};
            S_DONE:
            begin
                if (done_go)
                    sample_reg <= res_reg;
            end
            default: ;
        endcase
    end
endmodule

// ----- sim/enveloped_multiwave_oscillator_unit_tb.sv -----
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// enveloped_multiwave_oscillator_unit_tb
// self-checking bench for the enveloped multiwave oscillator
//------------------------------------------------------------------------------
// A directed table on all waveforms and a zero seed, then random words over
// several settings (random waveforms, extreme gains, increments, random seeds).
// Each sample is predicted by a behavioral oscillator model and checked in order.
//------------------------------------------------------------------------------
module enveloped_multiwave_oscillator_unit_tb;
    import emo_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        amp_env;
    logic [15:0]        freq_env;
    logic signed [15:0] fm_amount;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] sample_out;

    enveloped_multiwave_oscillator_unit u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amp_env    (amp_env),
        .freq_env   (freq_env),
        .fm_amount  (fm_amount),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    typedef struct {
        logic [15:0] amp;
        logic [15:0] freq;
        logic [15:0] fm;
        bit          known;
        logic [15:0] sample;
    } stim_row_t;

    // model state
    logic [2:0]  osc_wave;
    logic [31:0] osc_base_inc;
    logic [15:0] osc_amp;
    logic [31:0] osc_phase;
    logic [31:0] osc_noise;
    int          osc_brown;

    logic [15:0] sample_queue[$];
    int          fail_count;
    longint      cycle_count;
    bit          quiet_mode;
    bit          hold_off;
    stim_row_t   stim_table[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] noise_step();
        logic [31:0] r;
        r = osc_noise >> 1;
        if (osc_noise[0])
            r = r ^ 32'hD000_0001;
        osc_noise = r;
        return r;
    endfunction

    function automatic int sine_of(logic [31:0] ph);
        logic [31:0] p;
        longint unsigned f, z, z2, t;
        p = ph & ~((32'd1 << (32 - SineTableBits)) - 32'd1);
        f = (p >> 14) & 32'hFFFF;
        z = p[30] ? (65536 - f) : f;
        z2 = (z * z) >> 16;
        t = (4640 * z2) >> 16;
        t = 42048 - t;
        t = (t * z2) >> 16;
        t = 102944 - t;
        t = (t * z) >> 16;
        t = (t + 1) >> 1;
        if (t > 32767)
            t = 32767;
        return p[31] ? -int'(t) : int'(t);
    endfunction

    function automatic longint clip16(longint x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    function automatic int wave_at();
        bit neg;
        int walk, nxt;
        case (osc_wave)
            WaveSquare:   return osc_phase[31] ? 32767 : -32768;
            WaveTriangle:
                if (!osc_phase[31])
                    return -32768 + int'(osc_phase >> 15);
                else
                    return int'(clip16(98304 - longint'(osc_phase >> 15)));
            WaveSaw:      return int'(clip16(32768 - longint'(osc_phase >> 16)));
            WaveWhite:    return int'(noise_step() >> 16) - 32768;
            WavePink:     return 0;
            WaveBrown:
            begin
                neg = (noise_step() & 32'd1) != 32'd0;
                walk = int'(((longint'(noise_step() >> 16)) * 3277) >> 16);
                if (neg)
                    walk = -walk;
                nxt = osc_brown + walk;
                if (nxt > 32767 || nxt < -32768)
                    osc_brown = osc_brown - walk;
                else
                    osc_brown = nxt;
                return osc_brown;
            end
            default:      return sine_of(osc_phase);
        endcase
    endfunction

    function automatic logic [15:0] next_sample(logic [15:0] amp, logic [15:0] freq,
                                                logic [15:0] fm);
        longint unsigned gain, inc, delta;
        longint prod, q;
        int w;
        gain = (longint'(osc_amp) * amp) >> 15;
        if (gain > 65535)
            gain = 65535;
        w = wave_at();
        prod = longint'(gain) * w + 16384;
        q = (prod >= 0) ? prod / 32768 : -((-prod + 32767) / 32768);
        inc = (longint'(osc_base_inc) * freq) >> 15;
        if (inc > 64'hFFFF_FFFF)
            inc = 64'hFFFF_FFFF;
        delta = (inc * longint'(32768 + int'($signed(fm)))) >> 15;
        if (delta > 64'hFFFF_FFFF)
            delta = 64'hFFFF_FFFF;
        osc_phase = osc_phase + delta[31:0];
        return 16'(clip16(q));
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegWaveform:  osc_wave = val[2:0];
            RegBaseInc:   osc_base_inc = val;
            RegAmplitude: osc_amp = val[15:0];
            default:      osc_noise = val;
        endcase
    endtask

    task automatic send_word(stim_row_t row);
        logic [15:0] pred;
        @(posedge clk);
        while (!quiet_mode && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        amp_env   <= row.amp;
        freq_env  <= row.freq;
        fm_amount <= row.fm;
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 1'b0;
        pred = next_sample(row.amp, row.freq, row.fm);
        if (row.known && pred !== row.sample)
        begin
            $display("%0t: table row mismatch, expected %h, model gives %h",
                     $time, row.sample, pred);
            fail_count++;
        end
        sample_queue.push_back(row.known ? row.sample : pred);
    endtask

    task automatic drain();
        while (sample_queue.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic stim_row_t rand_row();
        stim_row_t r;
        r.amp   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        r.freq  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        r.fm    = 16'($urandom);
        r.known = 1'b0;
        return r;
    endfunction

    // receiver
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (sample_queue.size() == 0)
                begin
                    $display("%0t: unexpected sample, expected none, actual %h",
                             $time, sample_out);
                    fail_count++;
                end
                else if (sample_queue[0] !== sample_out)
                begin
                    $display("%0t: sample mismatch, expected %h, actual %h",
                             $time, sample_queue[0], sample_out);
                    fail_count++;
                    void'(sample_queue.pop_front());
                end
                else
                    void'(sample_queue.pop_front());
            end
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            out_stall <= !quiet_mode && ($urandom_range(99) < 21);
        end
    end

    initial
    begin
        stim_row_t row;
        logic [31:0] seed;
        fail_count = 0;
        quiet_mode = 1'b0;
        hold_off   = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        amp_env = '0;
        freq_env = '0;
        fm_amount = '0;
        osc_wave = WaveSine;
        osc_base_inc = BaseIncReset;
        osc_amp = AmpReset;
        osc_phase = '0;
        osc_noise = SeedReset;
        osc_brown = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // amp, freq, fm, known, sample
        stim_table = '{
            '{16'd32768, 16'd32768, 16'h0000, 1'b0, 16'h0000},
            '{16'd0,     16'd32768, 16'h7FFF, 1'b1, 16'h0000},
            '{16'hFFFF,  16'hFFFF,  16'h8000, 1'b0, 16'h0},
            '{16'd32768, 16'd0,     16'h8000, 1'b0, 16'h0},
            '{16'hFFFF,  16'd32768, 16'h7FFF, 1'b0, 16'h0},
            '{16'd32768, 16'hFFFF,  16'h7FFF, 1'b0, 16'h0},
            '{16'd1,     16'd1,     16'hFFFF, 1'b0, 16'h0},
            '{16'd16384, 16'd16384, 16'h4000, 1'b0, 16'h0}
        };
        // every waveform including selector seven, with a wrap-heavy increment
        reg_write(RegBaseInc, 32'hFFFF_FFFF);
        for (int w = 0; w < 8; w++)
        begin
            reg_write(RegWaveform, 32'(w));
            foreach (stim_table[i])
                send_word(stim_table[i]);
            drain();
        end
        // zero seed with noise waveforms
        reg_write(RegSeed, 32'd0);
        reg_write(RegWaveform, 32'(WaveWhite));
        row = '{16'd32768, 16'd32768, 16'h0000, 1'b1, 16'h8000};
        send_word(row);
        drain();
        reg_write(RegWaveform, 32'(WaveBrown));
        row = '{16'd32768, 16'd32768, 16'h0000, 1'b0, 16'h0000};
        send_word(row);
        drain();

        for (int phs = 0; phs < 10; phs++)
        begin
            reg_write(RegWaveform, 32'($urandom_range(7)));
            case (phs % 4)
                0: reg_write(RegBaseInc, 32'd0);
                1: reg_write(RegBaseInc, 32'hFFFF_FFFF);
                default: reg_write(RegBaseInc, $urandom);
            endcase
            reg_write(RegAmplitude, (phs == 2) ? 32'd0 :
                      (phs == 3) ? 32'hFFFF : 32'($urandom_range(32768)));
            seed = $urandom;
            reg_write(RegSeed, (phs == 5) ? 32'hFFFF_FFFF : (seed == 0 ? 32'd1 : seed));
            quiet_mode = (phs == 4);
            if (phs == 6)
                hold_off = 1'b1;
            repeat (44)
                send_word(rand_row());
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
